// ===== rtl/bpsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP pixel stream decoder package
// Shared types and fixed constants for the BMP byte stream parser.
// ----------------------------------------------------------------------------
package bpsd_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_SKIP,
		PH_PIXEL,
		PH_PAD,
		PH_DONE
	} phase_t;

	localparam logic [1:0] STATUS_PIXEL     = 2'd0;
	localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
	localparam logic [1:0] STATUS_BAD_DEPTH = 2'd2;
	localparam logic [1:0] STATUS_BAD_SIZE  = 2'd3;

	localparam logic [31:0] POS_MAGIC    = 32'd1;
	localparam logic [31:0] POS_OFFSET   = 32'd13;
	localparam logic [31:0] POS_WIDTH    = 32'd21;
	localparam logic [31:0] POS_HEIGHT   = 32'd25;
	localparam logic [31:0] POS_BPP      = 32'd29;
	localparam logic [31:0] POS_HDR_END  = 32'd37;
	localparam logic [31:0] POS_DATA_MIN = 32'd38;

	localparam logic [15:0] MAGIC_BM     = 16'h4D42;
	localparam logic [15:0] BPP_24       = 16'd24;
	localparam logic [15:0] BPP_32       = 16'd32;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [23:0] pixel_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic        last_pixel;
	} result_t;

endpackage

// ===== rtl/bpsd_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Captures one file byte per transfer and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module bpsd_in_stage
	import bpsd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     take,
	output logic     valid_s1,
	output in_item_t item_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/bpsd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP header and pixel parser
// Walks the header fields, skips to the pixel data and assembles RGBA pixels.
// ----------------------------------------------------------------------------
module bpsd_parser
	import bpsd_pkg::*;
#(
	parameter int MAX_DIM = 4096
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid_s1,
	input  in_item_t item_s1,
	input  logic     out_free,
	output logic     take,
	output logic     res_load,
	output result_t  res
);

	phase_t      phase_q, phase_c, phase_d;
	logic [31:0] pos_q, pos_c, pos_d;
	logic [31:0] hs_q, hs_c, hs_d;
	logic [31:0] off_q, off_c, off_d;
	logic [12:0] width_q, width_c, width_d;
	logic [12:0] height_q, height_c, height_d;
	logic        flip_q, flip_c, flip_d;
	logic        four_q, four_c, four_d;
	logic [12:0] row_q, row_c, row_d;
	logic [12:0] col_q, col_c, col_d;
	logic [1:0]  bip_q, bip_c, bip_d;
	logic [1:0]  pad_q, pad_c, pad_d;
	logic [23:0] pb_q, pb_c, pb_d;
	logic [1:0]  pend_q, pend_c, pend_d;
	logic [23:0] base_q, base_c, base_d;
	logic [23:0] prod_q;
	logic [12:0] height_m1;
	logic [25:0] prod_full;
	logic [31:0] hs_new;
	logic [31:0] mag;
	logic [7:0]  b;
	logic        fire;

	assign b = item_s1.data_byte;
	assign hs_new = {b, hs_c[31:8]};
	assign mag = hs_new[31] ? (~hs_new + 32'd1) : hs_new;
	assign height_m1 = height_q - 13'd1;
	assign prod_full = {13'b0, height_m1} * {13'b0, width_q};

	assign take = valid_s1 && (out_free || !fire);
	assign res_load = take && fire;

	always_comb begin
		logic        do_pixel;
		logic [1:0]  last_byte;
		logic        last;
		logic [12:0] col_inc;
		do_pixel = 1'b0;
		phase_c = phase_q;
		pos_c = pos_q;
		hs_c = hs_q;
		off_c = off_q;
		width_c = width_q;
		height_c = height_q;
		flip_c = flip_q;
		four_c = four_q;
		row_c = row_q;
		col_c = col_q;
		bip_c = bip_q;
		pad_c = pad_q;
		pb_c = pb_q;
		pend_c = pend_q;
		base_c = base_q;
		if (item_s1.file_start) begin
			phase_c = PH_HEADER;
			pos_c = '0;
			hs_c = '0;
			off_c = '0;
			width_c = '0;
			height_c = '0;
			flip_c = 1'b0;
			four_c = 1'b0;
			row_c = '0;
			col_c = '0;
			bip_c = '0;
			pad_c = '0;
			pb_c = '0;
			pend_c = '0;
			base_c = '0;
		end
		phase_d = phase_c;
		pos_d = pos_c;
		hs_d = hs_c;
		off_d = off_c;
		width_d = width_c;
		height_d = height_c;
		flip_d = flip_c;
		four_d = four_c;
		row_d = row_c;
		col_d = col_c;
		bip_d = bip_c;
		pad_d = pad_c;
		pb_d = pb_c;
		pend_d = pend_c;
		base_d = base_c;
		fire = 1'b0;
		res = '0;

		case (phase_c)
			PH_HEADER: begin
				hs_d = hs_new;
				if (pos_c == POS_MAGIC) begin
					if (hs_new[31:16] != MAGIC_BM) begin
						res.status = STATUS_BAD_MAGIC;
						fire = 1'b1;
						phase_d = PH_DONE;
					end
				end else if (pos_c == POS_OFFSET) begin
					off_d = hs_new;
				end else if (pos_c == POS_WIDTH) begin
					if (hs_new[31] || hs_new > 32'(MAX_DIM)) begin
						pend_d = STATUS_BAD_SIZE;
					end else begin
						width_d = hs_new[12:0];
					end
				end else if (pos_c == POS_HEIGHT) begin
					if (hs_new[31]) begin
						flip_d = 1'b1;
					end
					if (mag > 32'(MAX_DIM)) begin
						if (pend_c == STATUS_PIXEL) begin
							pend_d = STATUS_BAD_SIZE;
						end
					end else begin
						height_d = mag[12:0];
					end
				end else if (pos_c == POS_BPP) begin
					if (hs_new[31:16] == BPP_32) begin
						four_d = 1'b1;
					end else if (hs_new[31:16] != BPP_24) begin
						pend_d = STATUS_BAD_DEPTH;
					end
				end else if (pos_c == POS_HDR_END) begin
					if (pend_c != STATUS_PIXEL) begin
						res.status = pend_c;
						fire = 1'b1;
						phase_d = PH_DONE;
					end else if (width_c == '0 || height_c == '0) begin
						phase_d = PH_DONE;
					end else begin
						base_d = flip_c ? prod_q : '0;
						if (off_c[31] || off_c <= POS_DATA_MIN) begin
							phase_d = PH_PIXEL;
						end else begin
							phase_d = PH_SKIP;
						end
					end
				end
			end
			PH_SKIP: begin
				if (pos_c >= off_c) begin
					phase_d = PH_PIXEL;
					do_pixel = 1'b1;
				end
			end
			PH_PIXEL: begin
				do_pixel = 1'b1;
			end
			PH_PAD: begin
				if (pad_c != '0) begin
					pad_d = pad_c - 2'd1;
				end
				if (pad_d == '0) begin
					phase_d = PH_PIXEL;
				end
			end
			default: begin
			end
		endcase

		last_byte = four_c ? 2'd3 : 2'd2;
		last = (row_c == height_c - 13'd1) && (col_c == width_c - 13'd1);
		col_inc = col_c + 13'd1;
		if (do_pixel) begin
			if (bip_c < last_byte) begin
				case (bip_c)
					2'd0: pb_d[7:0] = pb_c[7:0] | b;
					2'd1: pb_d[15:8] = pb_c[15:8] | b;
					2'd2: pb_d[23:16] = pb_c[23:16] | b;
					default: pb_d = pb_c;
				endcase
				bip_d = bip_c + 2'd1;
			end else begin
				fire = 1'b1;
				res.status = STATUS_PIXEL;
				res.pixel_index = base_c + {11'b0, col_c};
				res.red = four_c ? pb_c[23:16] : b;
				res.green = pb_c[15:8];
				res.blue = pb_c[7:0];
				res.alpha = four_c ? b : ALPHA_OPAQUE;
				res.image_width = width_c;
				res.image_height = height_c;
				res.last_pixel = last;
				pb_d = '0;
				bip_d = '0;
				if (last) begin
					phase_d = PH_DONE;
				end else if (col_inc >= width_c) begin
					col_d = '0;
					row_d = row_c + 13'd1;
					base_d = flip_c ? (base_c - {11'b0, width_c}) : (base_c + {11'b0, width_c});
					if (!four_c && width_c[1:0] != 2'd0) begin
						pad_d = width_c[1:0];
						phase_d = PH_PAD;
					end
				end else begin
					col_d = col_inc;
				end
			end
		end

		if (phase_d != PH_IDLE && pos_c != '1) begin
			pos_d = pos_c + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q <= '0;
			hs_q <= '0;
			off_q <= '0;
			width_q <= '0;
			height_q <= '0;
			flip_q <= 1'b0;
			four_q <= 1'b0;
			row_q <= '0;
			col_q <= '0;
			bip_q <= '0;
			pad_q <= '0;
			pb_q <= '0;
			pend_q <= '0;
			base_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			hs_q <= hs_d;
			off_q <= off_d;
			width_q <= width_d;
			height_q <= height_d;
			flip_q <= flip_d;
			four_q <= four_d;
			row_q <= row_d;
			col_q <= col_d;
			bip_q <= bip_d;
			pad_q <= pad_d;
			pb_q <= pb_d;
			pend_q <= pend_d;
			base_q <= base_d;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_full[23:0];
	end

endmodule

// ===== rtl/bpsd_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the downstream side completes its transfer.
// ----------------------------------------------------------------------------
module bpsd_out_stage
	import bpsd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    out_free,
	input  logic    out_ready,
	output logic    out_valid,
	output result_t res_q
);

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ===== rtl/bmp_pixel_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP pixel stream decoder
// Parses a 24 or 32 bpp BMP byte stream and emits RGBA pixels with indices, or error reports.
// ----------------------------------------------------------------------------
// A result is loaded into the result register when the parser takes the byte that completes it.
// Throughput: one byte per cycle, but a byte that completes a result waits until the result register is free.
// The multiplier for the flipped row base is registered and has the header bytes to settle.
// Reset is asynchronous and active low; afterwards the parser waits for a file start.
module bmp_pixel_stream_decoder
	import bpsd_pkg::*;
#(
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        file_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [23:0] pixel_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [12:0] image_width,
	output logic [12:0] image_height,
	output logic        last_pixel
);

	in_item_t in_item;
	in_item_t item_s1;
	logic     valid_s1;
	logic     take;
	logic     res_load;
	logic     out_free;
	result_t  res;
	result_t  res_q;

	assign in_item.data_byte = data_byte;
	assign in_item.file_start = file_start;

	bpsd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bpsd_parser #(
		.MAX_DIM (MAX_DIM)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.take     (take),
		.res_load (res_load),
		.res      (res)
	);

	bpsd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.res       (res),
		.out_free  (out_free),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign status = res_q.status;
	assign pixel_index = res_q.pixel_index;
	assign red = res_q.red;
	assign green = res_q.green;
	assign blue = res_q.blue;
	assign alpha = res_q.alpha;
	assign image_width = res_q.image_width;
	assign image_height = res_q.image_height;
	assign last_pixel = res_q.last_pixel;

endmodule

// ===== rtl/bpsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP pixel stream decoder checker
// Port-level properties of the decoder's result channel.
// ----------------------------------------------------------------------------
module bpsd_checker
	import bpsd_pkg::*;
#(
	parameter int MAX_DIM = 4096
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [23:0] pixel_index,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic [7:0]  alpha,
	input logic [12:0] image_width,
	input logic [12:0] image_height,
	input logic        last_pixel
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_index) && $stable(status))
		else $error("A stalled result changed before its transfer.");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_PIXEL |-> pixel_index == '0 && red == '0 &&
		green == '0 && blue == '0 && alpha == '0 && image_width == '0 &&
		image_height == '0 && !last_pixel)
		else $error("An error result carries nonzero fields.");

	a_dims_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_PIXEL |-> image_width != '0 && image_height != '0 &&
		{19'b0, image_width} <= 32'(MAX_DIM) && {19'b0, image_height} <= 32'(MAX_DIM))
		else $error("A pixel was reported with out of range image dimensions.");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_PIXEL |->
		({13'b0, image_width} * {13'b0, image_height}) > {2'b0, pixel_index})
		else $error("A pixel index lies outside the image raster.");

endmodule

bind bmp_pixel_stream_decoder bpsd_checker #(
	.MAX_DIM (MAX_DIM)
) u_bpsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.pixel_index  (pixel_index),
	.red          (red),
	.green        (green),
	.blue         (blue),
	.alpha        (alpha),
	.image_width  (image_width),
	.image_height (image_height),
	.last_pixel   (last_pixel)
);

// ===== bench/bmp_pixel_stream_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP pixel stream decoder testbench
// Feeds BMP byte streams through the valid/ready input and checks every
// emitted pixel and error report against a behavioral decoder or a table of its own.
// A short table of magic-check cases comes first. Files that hit each header
// rule follow, then random files, broken files and noise, all under random
// idling on both sides. Includes one long output stall and full drains of the results.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder_test;
	import bpsd_pkg::*;

	localparam logic [31:0] SIZE_LIMIT = 32'd4096;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_BYTES = 400;
	localparam int MIN_RESULTS = 60;
	localparam int PRINT_CAP = 50;

	typedef struct packed {
		logic [7:0] b;
		logic       fs;
		bit         fixed_exp;
		bit         has_res;
		result_t    res;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        file_start;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [23:0] pixel_index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [12:0] image_width;
	logic [12:0] image_height;
	logic        last_pixel;

	bmp_pixel_stream_decoder #(
		.MAX_DIM(SIZE_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.file_start(file_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.pixel_index(pixel_index),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.image_width(image_width),
		.image_height(image_height),
		.last_pixel(last_pixel)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Decoder state mirrored from the byte stream.
	logic [31:0] dec_pos;
	phase_t      dec_phase;
	logic [31:0] dec_shift;
	logic [31:0] dec_offset;
	logic [12:0] dec_width;
	logic [12:0] dec_height;
	bit          dec_flip;
	bit          dec_quad;
	logic [12:0] dec_row;
	logic [12:0] dec_col;
	logic [1:0]  dec_slot;
	logic [1:0]  dec_pad;
	logic [23:0] dec_bytes;
	logic [1:0]  dec_err;

	stim_t   bytes_in_flight[$];
	result_t results_due[$];

	int cycle_count = 0;
	int mismatches = 0;
	int results_seen = 0;
	int results_predicted = 0;
	int bytes_accepted = 0;
	int pixels_checked = 0;
	int errors_checked = 0;
	int files_sent = 0;
	int counted_bytes = 0;
	int send_gap_max = 8;
	int recv_gap_max = 8;
	bit hold_request = 1'b0;

	stim_t   seen_item;
	bit      seen_got;
	result_t seen_res;
	result_t want_res;

	task automatic clear_decoder();
		dec_pos = '0;
		dec_phase = PH_IDLE;
		dec_shift = '0;
		dec_offset = '0;
		dec_width = '0;
		dec_height = '0;
		dec_flip = 1'b0;
		dec_quad = 1'b0;
		dec_row = '0;
		dec_col = '0;
		dec_slot = '0;
		dec_pad = '0;
		dec_bytes = '0;
		dec_err = STATUS_PIXEL;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic start, output bit got,
			output result_t r);
		logic [31:0] pos;
		logic [31:0] mag;
		logic [15:0] depth;
		logic [1:0]  last_slot;
		bit          take;
		bit          last;
		int unsigned row_out;
		int unsigned idx;
		int          pad_n;
		got = 1'b0;
		r = '0;
		take = 1'b0;
		if (start) begin
			clear_decoder();
			dec_phase = PH_HEADER;
		end
		pos = dec_pos;
		case (dec_phase)
			PH_HEADER: begin
				dec_shift = {b, dec_shift[31:8]};
				if (pos == POS_MAGIC) begin
					if (dec_shift[31:16] != MAGIC_BM) begin
						r.status = STATUS_BAD_MAGIC;
						got = 1'b1;
						dec_phase = PH_DONE;
					end
				end else if (pos == POS_OFFSET) begin
					dec_offset = dec_shift;
				end else if (pos == POS_WIDTH) begin
					if (dec_shift[31] || dec_shift > SIZE_LIMIT)
						dec_err = STATUS_BAD_SIZE;
					else
						dec_width = dec_shift[12:0];
				end else if (pos == POS_HEIGHT) begin
					mag = dec_shift;
					if (mag[31]) begin
						dec_flip = 1'b1;
						mag = -mag;
					end
					if (mag > SIZE_LIMIT) begin
						if (dec_err == STATUS_PIXEL)
							dec_err = STATUS_BAD_SIZE;
					end else begin
						dec_height = mag[12:0];
					end
				end else if (pos == POS_BPP) begin
					depth = dec_shift[31:16];
					if (depth == BPP_32)
						dec_quad = 1'b1;
					else if (depth != BPP_24)
						dec_err = STATUS_BAD_DEPTH;
				end else if (pos == POS_HDR_END) begin
					if (dec_err != STATUS_PIXEL) begin
						r.status = dec_err;
						got = 1'b1;
						dec_phase = PH_DONE;
					end else if (dec_width == 0 || dec_height == 0) begin
						dec_phase = PH_DONE;
					end else if (dec_offset[31] || dec_offset <= POS_DATA_MIN) begin
						dec_phase = PH_PIXEL;
					end else begin
						dec_phase = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (pos >= dec_offset) begin
					dec_phase = PH_PIXEL;
					take = 1'b1;
				end
			end
			PH_PIXEL: take = 1'b1;
			PH_PAD: begin
				if (dec_pad != 0)
					dec_pad--;
				if (dec_pad == 0)
					dec_phase = PH_PIXEL;
			end
			default: ;
		endcase
		if (take) begin
			last_slot = dec_quad ? 2'd3 : 2'd2;
			if (dec_slot < last_slot) begin
				dec_bytes[8*int'(dec_slot) +: 8] = b;
				dec_slot++;
			end else begin
				row_out = dec_flip ? dec_height - 1 - dec_row : dec_row;
				idx = row_out * dec_width + dec_col;
				last = (dec_row == dec_height - 1) && (dec_col == dec_width - 1);
				r.status = STATUS_PIXEL;
				r.pixel_index = idx[23:0];
				r.red = dec_quad ? dec_bytes[23:16] : b;
				r.green = dec_bytes[15:8];
				r.blue = dec_bytes[7:0];
				r.alpha = dec_quad ? b : ALPHA_OPAQUE;
				r.image_width = dec_width;
				r.image_height = dec_height;
				r.last_pixel = last;
				got = 1'b1;
				dec_bytes = '0;
				dec_slot = '0;
				if (last) begin
					dec_phase = PH_DONE;
				end else begin
					dec_col++;
					if (dec_col >= dec_width) begin
						dec_col = '0;
						dec_row++;
						pad_n = dec_quad ? 0 : (4 - ((3 * int'(dec_width)) & 3)) & 3;
						if (pad_n != 0) begin
							dec_pad = pad_n[1:0];
							dec_phase = PH_PAD;
						end
					end
				end
			end
		end
		if (dec_phase != PH_IDLE && dec_pos != '1)
			dec_pos++;
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("MISMATCH at result %0d: %s", results_seen, msg);
	endtask

	task automatic check_field(input string name, input int unsigned got_v,
			input int unsigned want_v);
		if (got_v != want_v)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got_v, want_v));
	endtask

	function automatic logic [7:0] rand_byte();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		return 8'($urandom());
	endfunction

	function automatic stim_t fixed_row(input logic [7:0] b, input logic fs, input bit has_res);
		stim_t s;
		s = '0;
		s.b = b;
		s.fs = fs;
		s.fixed_exp = 1'b1;
		s.has_res = has_res;
		if (has_res)
			s.res.status = STATUS_BAD_MAGIC;
		return s;
	endfunction

	task automatic send_byte(input stim_t s);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= s.b;
		file_start <= s.fs;
		bytes_in_flight.push_back(s);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due.size() != 0 || bytes_in_flight.size() != 0);
	endtask

	task automatic send_file(input logic [31:0] w_f, input logic [31:0] h_f,
			input logic [15:0] depth, input logic [31:0] off, input int cut, input bit steady);
		logic [7:0]  hdr [38];
		logic [31:0] hmag;
		stim_t       s;
		bit          ok;
		int          bpb;
		int          pad_n;
		int          filler;
		int          total;
		int          i;
		for (i = 0; i < 38; i++)
			hdr[i] = rand_byte();
		{hdr[1], hdr[0]} = MAGIC_BM;
		{hdr[13], hdr[12], hdr[11], hdr[10]} = off;
		{hdr[21], hdr[20], hdr[19], hdr[18]} = w_f;
		{hdr[25], hdr[24], hdr[23], hdr[22]} = h_f;
		{hdr[29], hdr[28]} = depth;
		hmag = h_f[31] ? -h_f : h_f;
		ok = !w_f[31] && w_f != 0 && w_f <= SIZE_LIMIT && hmag != 0 && hmag <= SIZE_LIMIT
			&& (depth == BPP_24 || depth == BPP_32);
		bpb = (depth == BPP_32) ? 4 : 3;
		pad_n = (bpb == 4) ? 0 : (4 - ((3 * int'(w_f)) & 3)) & 3;
		filler = (!off[31] && off > POS_DATA_MIN) ? int'(off) - 38 : 0;
		total = 38;
		if (ok)
			total += filler + int'(hmag) * (int'(w_f) * bpb + pad_n);
		if (cut >= 0 && cut < total)
			total = cut;
		send_gap_max = (steady || $urandom_range(0, 2) == 0) ? 0 : 8;
		for (i = 0; i < total; i++) begin
			s = '0;
			s.b = (i < 38) ? hdr[i] : rand_byte();
			s.fs = (i == 0);
			send_byte(s);
		end
		counted_bytes += total;
		files_sent++;
		repeat ($urandom_range(0, 3)) begin
			s = '0;
			s.b = rand_byte();
			send_byte(s);
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, results_due.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen_item = bytes_in_flight.pop_front();
				decode_byte(seen_item.b, seen_item.fs, seen_got, seen_res);
				if (seen_item.fixed_exp) begin
					seen_got = seen_item.has_res;
					seen_res = seen_item.res;
				end
				if (seen_got) begin
					results_due.push_back(seen_res);
					results_predicted++;
				end
				bytes_accepted++;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (results_due.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					want_res = results_due.pop_front();
					check_field("status", status, want_res.status);
					check_field("pixel_index", pixel_index, want_res.pixel_index);
					check_field("red", red, want_res.red);
					check_field("green", green, want_res.green);
					check_field("blue", blue, want_res.blue);
					check_field("alpha", alpha, want_res.alpha);
					check_field("image_width", image_width, want_res.image_width);
					check_field("image_height", image_height, want_res.image_height);
					check_field("last_pixel", last_pixel, want_res.last_pixel);
					if (want_res.status == STATUS_PIXEL)
						pixels_checked++;
					else
						errors_checked++;
				end
			end
		end
	end

	initial begin
		int gap;
		int taken;
		taken = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = $urandom_range(0, recv_gap_max);
				if (gap != 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
			if (taken % 16 == 0)
				recv_gap_max = $urandom_range(0, 1) ? 8 : 0;
		end
	end

	initial begin
		stim_t       opening_rows [19];
		stim_t       s;
		logic [31:0] w;
		logic [31:0] h;
		logic [31:0] hm;
		logic [31:0] off;
		logic [15:0] depth;
		int          kind;
		int          cut;
		int          rand_files;
		int          i;
		in_valid <= 1'b0;
		data_byte <= '0;
		file_start <= 1'b0;
		arst_n <= 1'b0;
		clear_decoder();
		opening_rows = '{
			fixed_row(8'h42, 1'b0, 1'b0), fixed_row(8'hFF, 1'b0, 1'b0),
			fixed_row(8'h42, 1'b1, 1'b0), fixed_row(8'h00, 1'b0, 1'b1),
			fixed_row(8'h4D, 1'b0, 1'b0),
			fixed_row(8'h42, 1'b1, 1'b0), fixed_row(8'h4D, 1'b0, 1'b0),
			fixed_row(8'h00, 1'b0, 1'b0),
			fixed_row(8'h4D, 1'b1, 1'b0), fixed_row(8'h42, 1'b0, 1'b1),
			fixed_row(8'h42, 1'b1, 1'b0), fixed_row(8'h4D, 1'b0, 1'b0),
			fixed_row(8'h42, 1'b1, 1'b0), fixed_row(8'hFF, 1'b0, 1'b1),
			fixed_row(8'h00, 1'b1, 1'b0), fixed_row(8'h00, 1'b0, 1'b1),
			fixed_row(8'hFF, 1'b1, 1'b0), fixed_row(8'hFF, 1'b0, 1'b1),
			fixed_row(8'h5A, 1'b0, 1'b0)
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 19; i++)
			send_byte(opening_rows[i]);
		wait_all_results();

		send_file(32'd1, 32'd1, BPP_24, 32'd54, -1, 1'b0);
		send_file(32'd2, 32'd2, BPP_24, 32'd38, -1, 1'b0);
		send_file(32'd3, -32'd2, BPP_24, 32'd0, -1, 1'b0);
		send_file(32'd2, -32'd3, BPP_32, 32'h8000_0010, -1, 1'b0);
		send_file(32'd4, 32'd1, BPP_24, 32'd40, -1, 1'b0);
		send_file(32'd5000, 32'd2, 16'd8, 32'd54, -1, 1'b0);
		send_file(-32'd1, 32'd2, BPP_24, 32'd54, -1, 1'b0);
		send_file(32'd4097, 32'd1, BPP_32, 32'd54, -1, 1'b0);
		send_file(32'd2, 32'h8000_0000, BPP_24, 32'd54, -1, 1'b0);
		send_file(32'd2, -32'd4097, BPP_24, 32'd54, -1, 1'b0);
		send_file(32'd4096, 32'd0, BPP_32, 32'd54, -1, 1'b0);
		send_file(32'd0, -32'd4096, BPP_24, 32'd54, -1, 1'b0);
		send_file(32'd1, -32'd4096, BPP_24, 32'd38, 70, 1'b0);
		send_file(32'd4096, 32'd1, BPP_32, 32'd38, 70, 1'b0);
		hold_request = 1'b1;
		send_file(32'd6, 32'd4, BPP_32, 32'd38, -1, 1'b1);

		counted_bytes = 0;
		rand_files = 0;
		while (counted_bytes < RANDOM_BYTES || results_predicted < MIN_RESULTS) begin
			if (rand_files == 4)
				wait_all_results();
			rand_files++;
			kind = $urandom_range(0, 15);
			w = $urandom_range(1, 6);
			hm = $urandom_range(1, 4);
			h = $urandom_range(0, 1) ? -hm : hm;
			depth = $urandom_range(0, 1) ? BPP_32 : BPP_24;
			case ($urandom_range(0, 3))
				0: off = $urandom_range(0, 38);
				3: off = {1'b1, 31'($urandom())};
				default: off = 32'd38 + $urandom_range(1, 6);
			endcase
			cut = -1;
			case (kind)
				0, 1: begin
					repeat ($urandom_range(1, 4)) begin
						s = '0;
						s.b = rand_byte();
						send_byte(s);
					end
				end
				2: begin
					for (i = 0; i < $urandom_range(2, 5); i++) begin
						s = '0;
						s.fs = (i == 0);
						if (i == 0)
							s.b = $urandom_range(0, 1) ? MAGIC_BM[7:0] : rand_byte();
						else if (i == 1)
							s.b = $urandom_range(0, 1) ? MAGIC_BM[15:8] : rand_byte();
						else
							s.b = rand_byte();
						send_byte(s);
						counted_bytes++;
					end
					files_sent++;
				end
				3: depth = 16'($urandom());
				4: begin
					case ($urandom_range(0, 3))
						0: w = {1'b1, 31'($urandom())};
						1: w = 32'd4097 + $urandom_range(0, 60000);
						2: h = 32'h8000_0000;
						default: begin
							hm = 32'd4097 + $urandom_range(0, 60000);
							h = $urandom_range(0, 1) ? -hm : hm;
						end
					endcase
				end
				5: begin
					if ($urandom_range(0, 1))
						w = '0;
					else
						h = '0;
				end
				6, 7: cut = $urandom_range(1, 50);
				default: ;
			endcase
			if (kind >= 3)
				send_file(w, h, depth, off, cut, 1'b0);
		end

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d byte transfers over %0d files and fragments.",
			bytes_accepted, files_sent);
		$display("Checked %0d pixel results and %0d error reports, %0d mismatches.",
			pixels_checked, errors_checked, mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
